[rtl/core/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants
// Field widths, reset values and the scan-control bundle used by the
// slope-sign peak detector.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int TIME_W         = 32;
  localparam int SPAN_W         = 16;
  localparam int WINDOW_LEN_DEF = 8;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 16'd200;

  typedef struct packed {
    logic clear;
    logic step;
  } acc_ctrl_t;

endpackage

[rtl/core/ssp_sample_if.sv]
// ----------------------------------------------------------------------------
// ssp_sample_if: sample request channel
// Valid/ready channel carrying one timestamped sensor sample per request.
// ----------------------------------------------------------------------------
interface ssp_sample_if;
  import ssp_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_value;
  logic [TIME_W-1:0]   sample_time;

  modport source (output valid, output sample_value, output sample_time, input ready);
  modport sink   (input valid, input sample_value, input sample_time, output ready);

endinterface

[rtl/core/ssp_peak_if.sv]
// ----------------------------------------------------------------------------
// ssp_peak_if: peak request channel
// Valid/ready channel carrying one detected peak per request.
// ----------------------------------------------------------------------------
interface ssp_peak_if;
  import ssp_pkg::*;

  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   peak_time;
  logic [SAMPLE_W-1:0] peak_amp;

  modport source (output valid, output peak_time, output peak_amp, input ready);
  modport sink   (input valid, input peak_time, input peak_amp, output ready);

endinterface

[rtl/core/ssp_cell.sv]
// ----------------------------------------------------------------------------
// ssp_cell: window cell
// Holds one sample of the window; takes its neighbor's value when loaded.
// ----------------------------------------------------------------------------
module ssp_cell (
  input  logic                         clk,
  input  logic                         load,
  input  logic [ssp_pkg::SAMPLE_W-1:0] din,
  output logic [ssp_pkg::SAMPLE_W-1:0] dout
);
  import ssp_pkg::*;

  logic [SAMPLE_W-1:0] value;

  always_ff @(posedge clk) begin
    if (load) begin
      value <= din;
    end
  end

  assign dout = value;

endmodule

[rtl/core/ssp_accum.sv]
// ----------------------------------------------------------------------------
// ssp_accum: slope and maximum accumulator
// Takes one window sample per step, oldest first, and accumulates the
// slope numerator sum((2i-(N-1))*p[i]) and the first maximum with its index.
// ----------------------------------------------------------------------------
module ssp_accum #(
  parameter int N = ssp_pkg::WINDOW_LEN_DEF
) (
  input  logic                         clk,
  input  ssp_pkg::acc_ctrl_t           ctrl,
  input  logic [$clog2(N)-1:0]         idx,
  input  logic [ssp_pkg::SAMPLE_W-1:0] p,
  output logic                         positive,
  output logic [ssp_pkg::SAMPLE_W-1:0] best,
  output logic [$clog2(N)-1:0]         best_idx
);
  import ssp_pkg::*;

  localparam int IDXW = $clog2(N);
  localparam int CW   = IDXW + 2;
  localparam int SLW  = SAMPLE_W + 2 * IDXW + 2;
  localparam logic signed [CW-1:0] COEF_OFS = CW'(N - 1);

  logic signed [SLW-1:0] slope;
  logic signed [CW-1:0]  coef;
  logic signed [SLW-1:0] term;

  assign coef = $signed({1'b0, idx, 1'b0}) - COEF_OFS;
  assign term = SLW'(coef) * SLW'($signed({1'b0, p}));

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      slope    <= '0;
      best     <= '0;
      best_idx <= '0;
    end else if (ctrl.step) begin
      slope <= slope + term;
      if (p > best) begin
        best     <= p;
        best_idx <= idx;
      end
    end
  end

  assign positive = (slope > 0);

endmodule

[rtl/core/ssp_div.sv]
// ----------------------------------------------------------------------------
// ssp_div: divide by window length
// Reciprocal multiply by the constant 1/N; start registers the dividend and
// sets busy, and the quotient is registered as busy clears.
// ----------------------------------------------------------------------------
module ssp_div #(
  parameter int N  = ssp_pkg::WINDOW_LEN_DEF,
  parameter int PW = $clog2(N) + ssp_pkg::SPAN_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] dividend,
  output logic          busy,
  output logic [PW-1:0] quotient
);
  import ssp_pkg::*;

  localparam int IDXW = $clog2(N);
  localparam int SH   = PW + IDXW;
  localparam int FW   = PW + SH;
  localparam longint RECIP_L = ((longint'(1) << SH) + longint'(N - 1)) / longint'(N);
  localparam logic [SH-1:0] RECIP = SH'(RECIP_L);

  logic [PW-1:0] dvd;
  logic [FW-1:0] scaled;

  assign scaled = FW'(dvd) * FW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      dvd  <= dividend;
    end else if (busy) begin
      busy     <= 1'b0;
      quotient <= scaled[FW-1:SH];
    end
  end

endmodule

[rtl/core/slope_sign_peak_detector.sv]
// ----------------------------------------------------------------------------
// slope_sign_peak_detector: sliding-window slope-sign peak detector
// Keeps the last N samples in a row of cells, scans them for the regression
// slope sign and first maximum, and reports a peak on a positive-to-
// non-positive slope change.
//
//   channel   dir  fields                       handshake
//   samples   in   sample_value, sample_time    valid/ready
//   peaks     out  peak_time, peak_amp          valid/ready
//   cfg       in   cfg_wdata (window_span_ms)   cfg_wen, no wait
//
// A sample taken while the window fills just shifts in; ready stays high.
// A sample on a full window starts a scan: the cells rotate once around
// the ring, feeding the accumulator one entry per cycle, then a decide step.
// A peak adds the reciprocal multiply by 1/N in S_DIV and the output write
// in S_EMIT.
// Reset clears fill count, slope history and the output valid flag, and sets
// the span to 200.
// A stalled peak holds the block before its output write only.
// ----------------------------------------------------------------------------
module slope_sign_peak_detector #(
  parameter int WINDOW_LEN = ssp_pkg::WINDOW_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  ssp_sample_if.sink                 samples,
  ssp_peak_if.source                 peaks,
  input  logic                       cfg_wen,
  input  logic [ssp_pkg::SPAN_W-1:0] cfg_wdata
);
  import ssp_pkg::*;

  localparam int N     = WINDOW_LEN;
  localparam int IDXW  = $clog2(N);
  localparam int FILLW = $clog2(N + 1);
  localparam int PW    = IDXW + SPAN_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DECIDE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t              state;
  logic [FILLW-1:0]    fill_count;
  logic                last_pos;
  logic [TIME_W-1:0]   time_reg;
  logic [IDXW-1:0]     walk_idx;
  logic [SPAN_W-1:0]   span;
  logic                out_valid;
  logic [TIME_W-1:0]   out_time;
  logic [SAMPLE_W-1:0] out_amp;
  logic [PW-1:0]       prod;

  logic                accept;
  logic                cell_load;
  logic [SAMPLE_W-1:0] cell_q [N];
  logic [SAMPLE_W-1:0] feed;
  acc_ctrl_t           acc_ctrl;
  logic                positive;
  logic [SAMPLE_W-1:0] best;
  logic [IDXW-1:0]     best_idx;
  logic                div_start;
  logic                div_busy;
  logic [PW-1:0]       quotient;

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign cell_load     = accept || (state == S_WALK);
  assign feed          = (state == S_WALK) ? cell_q[0] : samples.sample_value;

  for (genvar k = 0; k < N; k++) begin : g_cell
    if (k == N - 1) begin : g_last
      ssp_cell u_cell (.clk(clk), .load(cell_load), .din(feed), .dout(cell_q[k]));
    end else begin : g_mid
      ssp_cell u_cell (.clk(clk), .load(cell_load), .din(cell_q[k+1]), .dout(cell_q[k]));
    end
  end

  assign acc_ctrl.clear = accept;
  assign acc_ctrl.step  = (state == S_WALK);

  ssp_accum #(.N(N)) u_accum (
    .clk      (clk),
    .ctrl     (acc_ctrl),
    .idx      (walk_idx),
    .p        (cell_q[0]),
    .positive (positive),
    .best     (best),
    .best_idx (best_idx)
  );

  assign div_start = (state == S_DECIDE) && last_pos && !positive;
  assign prod      = PW'(best_idx) * PW'(span);

  ssp_div #(.N(N), .PW(PW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      last_pos   <= 1'b0;
      walk_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && peaks.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            time_reg <= samples.sample_time;
            walk_idx <= '0;
            if (fill_count != FILLW'(N)) begin
              fill_count <= fill_count + 1'b1;
            end
            if (fill_count >= FILLW'(N - 1)) begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          walk_idx <= walk_idx + 1'b1;
          if (walk_idx == IDXW'(N - 1)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          last_pos <= positive;
          state    <= div_start ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (!div_busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || peaks.ready) begin
            out_valid <= 1'b1;
            out_time  <= time_reg + TIME_W'(quotient);
            out_amp   <= best;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span <= SPAN_RESET;
    end else if (cfg_wen) begin
      span <= cfg_wdata;
    end
  end

  assign peaks.valid     = out_valid;
  assign peaks.peak_time = out_time;
  assign peaks.peak_amp  = out_amp;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILLW'(N))
    else $error("fill count beyond window length");

  a_full_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && fill_count >= FILLW'(N - 1)) |=> (state == S_WALK && walk_idx == '0))
    else $error("full window request did not start a scan");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && walk_idx == IDXW'(N - 1)) |=> state == S_DECIDE)
    else $error("scan did not end after N steps");

  a_peak_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("peak request raised outside emit");

endmodule
